// ===== sv/bbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, result kinds and bracket character helpers for the bracket
// balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int DefaultStackDepth = 16;

   // Result kinds carried on rsp_tuser.
   typedef enum logic [2:0] {
      KIND_FULL      = 3'd0,
      KIND_NO_OPENER = 3'd1,
      KIND_NO_CLOSER = 3'd2,
      KIND_CORRECT   = 3'd3,
      KIND_WRONG     = 3'd4
   } kind_type;

   // Two-bit codes held on the stack.
   localparam logic [1:0] CODE_PAREN = 2'd0;
   localparam logic [1:0] CODE_BRACE = 2'd1;
   localparam logic [1:0] CODE_SQUARE = 2'd2;

   localparam logic [7:0] CHAR_OPEN_PAREN = 8'h28;
   localparam logic [7:0] CHAR_OPEN_BRACE = 8'h7B;
   localparam logic [7:0] CHAR_OPEN_SQUARE = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE_PAREN = 8'h29;
   localparam logic [7:0] CHAR_CLOSE_BRACE = 8'h7D;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;

   typedef struct packed {
      logic       hit;
      logic [1:0] code;
   } match_type;

   function automatic match_type opener_of(input logic [7:0] ch);
      match_type m;
      m.hit = 1'b1;
      m.code = CODE_PAREN;
      case (ch)
         CHAR_OPEN_PAREN:  m.code = CODE_PAREN;
         CHAR_OPEN_BRACE:  m.code = CODE_BRACE;
         CHAR_OPEN_SQUARE: m.code = CODE_SQUARE;
         default:          m.hit = 1'b0;
      endcase
      return m;
   endfunction

   function automatic match_type closer_of(input logic [7:0] ch);
      match_type m;
      m.hit = 1'b1;
      m.code = CODE_PAREN;
      case (ch)
         CHAR_CLOSE_PAREN:  m.code = CODE_PAREN;
         CHAR_CLOSE_BRACE:  m.code = CODE_BRACE;
         CHAR_CLOSE_SQUARE: m.code = CODE_SQUARE;
         default:           m.hit = 1'b0;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] opener_char(input logic [1:0] code);
      logic [7:0] ch;
      case (code)
         CODE_BRACE:  ch = CHAR_OPEN_BRACE;
         CODE_SQUARE: ch = CHAR_OPEN_SQUARE;
         default:     ch = CHAR_OPEN_PAREN;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== sv/bracket_balance_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Checks bracket balance of a character stream with an opener stack held in
// a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character per transaction in req_tdata; req_tlast marks
//   the end of an expression (its character is ignored). rsp_* returns the
//   results: rsp_tuser is the kind, rsp_tdata the bracket concerned (zero for
//   correct and wrong), rsp_tlast marks the final result of one input
//   transaction. Characters that cause no result give no rsp transaction.
//   Each input transaction passes through the stack path in order: the top
//   entry is read from the stack memory while the character is taken, then
//   it is compared and pushed or popped. A transaction that yields results
//   occupies the block until its last result has been taken. At an end
//   marker the stack is drained top first, one no-closer result per unclosed
//   opener, and then one wrong result follows. While rsp_tready is low the
//   pending result is held and no new request is taken. Reset empties the
//   stack and clears the abort flag; the memory contents need no clearing
//   since only written entries are read.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top #(
   parameter int STACK_DEPTH = bbc_pkg::DefaultStackDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] symbol
   input  wire logic       req_tlast,   // end_marker
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] bracket
   output logic [2:0]      rsp_tuser,   // [2:0] kind
   output logic            rsp_tlast    // last
);

   localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DepthW = $clog2(STACK_DEPTH + 1);
   localparam logic [DepthW-1:0] FullDepth = DepthW'(STACK_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   typedef enum logic [1:0] {
      AFTER_IDLE,
      AFTER_DRAIN,
      AFTER_WRONG
   } after_type;

   logic [1:0] stack_mem [STACK_DEPTH];
   logic [1:0] rd_data_ff;
   logic [AddrW-1:0] rd_addr;
   logic [DepthW-1:0] depth_minus_one;
   logic wr_en;
   logic [1:0] wr_code;

   state_type state_ff, state_in;
   after_type after_ff, after_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic aborted_ff, aborted_in;
   logic [7:0] sym_ff, sym_in;
   logic end_ff, end_in;
   logic valid_ff, valid_in;
   logic [7:0] bracket_ff, bracket_in;
   logic [2:0] kind_ff, kind_in;
   logic last_ff, last_in;

   bbc_pkg::match_type open_m;
   bbc_pkg::match_type close_m;

   // The top entry is always read at depth - 1; a push or pop updates depth
   // before the registered read for the next compare or drain step is taken.
   assign depth_minus_one = depth_ff - DepthW'(1);
   assign rd_addr = depth_minus_one[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[depth_ff[AddrW-1:0]] <= wr_code;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign open_m = bbc_pkg::opener_of(sym_ff);
   assign close_m = bbc_pkg::closer_of(sym_ff);

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      depth_in = depth_ff;
      aborted_in = aborted_ff;
      sym_in = sym_ff;
      end_in = end_ff;
      valid_in = valid_ff;
      bracket_in = bracket_ff;
      kind_in = kind_ff;
      last_in = last_ff;
      wr_en = 1'b0;
      wr_code = open_m.code;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sym_in = req_tdata;
               end_in = req_tlast;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (end_ff) begin
               if (aborted_ff) begin
                  aborted_in = 1'b0;
                  depth_in = '0;
               end else if (depth_ff == '0) begin
                  valid_in = 1'b1;
                  kind_in = bbc_pkg::KIND_CORRECT;
                  bracket_in = '0;
                  last_in = 1'b1;
                  after_in = AFTER_IDLE;
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_DRAIN;
               end
            end else if (!aborted_ff) begin
               if (open_m.hit) begin
                  if (depth_ff == FullDepth) begin
                     valid_in = 1'b1;
                     kind_in = bbc_pkg::KIND_FULL;
                     bracket_in = sym_ff;
                     last_in = 1'b1;
                     after_in = AFTER_IDLE;
                     state_in = ST_HOLD;
                  end else begin
                     wr_en = 1'b1;
                     depth_in = depth_ff + DepthW'(1);
                  end
               end else if (close_m.hit) begin
                  if (depth_ff == '0) begin
                     valid_in = 1'b1;
                     kind_in = bbc_pkg::KIND_NO_OPENER;
                     bracket_in = sym_ff;
                     last_in = 1'b0;
                     aborted_in = 1'b1;
                     after_in = AFTER_WRONG;
                     state_in = ST_HOLD;
                  end else if (rd_data_ff == close_m.code) begin
                     depth_in = depth_minus_one;
                  end
               end
            end
         end
         ST_DRAIN: begin
            valid_in = 1'b1;
            kind_in = bbc_pkg::KIND_NO_CLOSER;
            bracket_in = bbc_pkg::opener_char(rd_data_ff);
            last_in = 1'b0;
            depth_in = depth_minus_one;
            after_in = (depth_ff == DepthW'(1)) ? AFTER_WRONG : AFTER_DRAIN;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               unique case (after_ff)
                  AFTER_DRAIN: state_in = ST_DRAIN;
                  AFTER_WRONG: begin
                     valid_in = 1'b1;
                     kind_in = bbc_pkg::KIND_WRONG;
                     bracket_in = '0;
                     last_in = 1'b1;
                     after_in = AFTER_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= AFTER_IDLE;
         depth_ff <= '0;
         aborted_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         depth_ff <= depth_in;
         aborted_ff <= aborted_in;
         valid_ff <= valid_in;
      end
      sym_ff <= sym_in;
      end_ff <= end_in;
      bracket_ff <= bracket_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = bracket_ff;
   assign rsp_tuser = kind_ff;
   assign rsp_tlast = last_ff;

endmodule
`default_nettype wire

// ===== dv/bracket_report_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_report_checker
// Watches both streams of the bracket balance checker, keeps its own bracket
// stack to work out the reports each request transaction must produce, and
// compares every response transaction against the oldest outstanding report.
// ----------------------------------------------------------------------------
module bracket_report_checker #(
   parameter int STACK_DEPTH = bbc_pkg::DefaultStackDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,
   input  wire logic [2:0] rsp_tuser,
   input  wire logic       rsp_tlast,
   output int              mismatch_count,
   output int              reports_pending
);

   typedef struct packed {
      bbc_pkg::kind_type kind;
      logic [7:0]        bracket;
      logic              last;
   } report_type;

   report_type expected_reports[$];
   logic [7:0] open_stack [STACK_DEPTH];
   int         depth;
   bit         aborted;

   function automatic logic [7:0] partner_of(input logic [7:0] closer);
      case (closer)
         bbc_pkg::CHAR_CLOSE_PAREN:  return bbc_pkg::CHAR_OPEN_PAREN;
         bbc_pkg::CHAR_CLOSE_BRACE:  return bbc_pkg::CHAR_OPEN_BRACE;
         bbc_pkg::CHAR_CLOSE_SQUARE: return bbc_pkg::CHAR_OPEN_SQUARE;
         default:                    return 8'h00;
      endcase
   endfunction

   function automatic bit is_opener(input logic [7:0] ch);
      return ch == bbc_pkg::CHAR_OPEN_PAREN || ch == bbc_pkg::CHAR_OPEN_BRACE ||
             ch == bbc_pkg::CHAR_OPEN_SQUARE;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_report(input bbc_pkg::kind_type kind, input logic [7:0] bracket,
                               input logic last);
      report_type entry;
      entry.kind = kind;
      entry.bracket = bracket;
      entry.last = last;
      expected_reports.push_back(entry);
   endtask

   task automatic predict_reports(input logic [7:0] sym, input logic eom);
      logic [7:0] partner;
      partner = partner_of(sym);
      if (eom) begin
         // An aborted expression already reported its failure.
         if (!aborted) begin
            if (depth == 0) begin
               queue_report(bbc_pkg::KIND_CORRECT, 8'h00, 1'b1);
            end else begin
               while (depth > 0) begin
                  depth--;
                  queue_report(bbc_pkg::KIND_NO_CLOSER, open_stack[depth], 1'b0);
               end
               queue_report(bbc_pkg::KIND_WRONG, 8'h00, 1'b1);
            end
         end
         depth = 0;
         aborted = 1'b0;
      end else if (!aborted) begin
         if (is_opener(sym)) begin
            if (depth >= STACK_DEPTH) begin
               queue_report(bbc_pkg::KIND_FULL, sym, 1'b1);
            end else begin
               open_stack[depth] = sym;
               depth++;
            end
         end else if (partner != 8'h00) begin
            if (depth == 0) begin
               queue_report(bbc_pkg::KIND_NO_OPENER, sym, 1'b0);
               queue_report(bbc_pkg::KIND_WRONG, 8'h00, 1'b1);
               aborted = 1'b1;
            end else if (open_stack[depth - 1] == partner) begin
               depth--;
            end
         end
      end
   endtask

   task automatic check_report(input logic [2:0] kind, input logic [7:0] bracket,
                               input logic last);
      report_type want;
      if (expected_reports.size() == 0) begin
         flag_mismatch($sformatf("unexpected result kind %0d bracket 0x%02h last %0b",
                                 kind, bracket, last));
         return;
      end
      want = expected_reports.pop_front();
      if (kind !== want.kind)
         flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (bracket !== want.bracket)
         flag_mismatch($sformatf("bracket 0x%02h, expected 0x%02h", bracket, want.bracket));
      if (last !== want.last)
         flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         depth = 0;
         aborted = 1'b0;
         expected_reports.delete();
      end else begin
         // A response can never belong to the request taken at the same edge.
         if (rsp_tvalid && rsp_tready) check_report(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) predict_reports(req_tdata, req_tlast);
      end
      reports_pending = expected_reports.size();
   end

endmodule
`default_nettype wire

// ===== dv/tb_bracket_balance_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker_top
// Feeds the bracket balance checker with directed expressions and then with
// random ones, mostly well nested with random noise, some broken or deep
// enough to overflow the stack, under random stalls on both streams outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker_top;

   localparam int RANDOM_ITEMS = 400;
   // Wait after the last expected result, scaled from the stack depth.
   localparam int DRAIN_CYCLES = 2 * bbc_pkg::DefaultStackDepth + 20;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;
   int         fail_count;
   int         results_pending;
   int         counted_items;
   bit         steady;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   bracket_balance_checker_top #(
      .STACK_DEPTH(bbc_pkg::DefaultStackDepth)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   bracket_report_checker #(
      .STACK_DEPTH(bbc_pkg::DefaultStackDepth)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .mismatch_count(fail_count),
      .reports_pending(results_pending)
   );

   function automatic logic [7:0] opener_byte(input logic [1:0] code);
      case (code)
         bbc_pkg::CODE_BRACE:  return bbc_pkg::CHAR_OPEN_BRACE;
         bbc_pkg::CODE_SQUARE: return bbc_pkg::CHAR_OPEN_SQUARE;
         default:              return bbc_pkg::CHAR_OPEN_PAREN;
      endcase
   endfunction

   function automatic logic [7:0] closer_byte(input logic [1:0] code);
      case (code)
         bbc_pkg::CODE_BRACE:  return bbc_pkg::CHAR_CLOSE_BRACE;
         bbc_pkg::CODE_SQUARE: return bbc_pkg::CHAR_CLOSE_SQUARE;
         default:              return bbc_pkg::CHAR_CLOSE_PAREN;
      endcase
   endfunction

   // Called and returning at a falling edge; tvalid stays high into the next
   // transaction unless a random idle is drawn.
   task automatic push_item(input logic [7:0] sym, input logic eom);
      while (!steady && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sym;
      req_tlast <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      counted_items++;
   endtask

   task automatic pause_for_results();
      req_tvalid <= 1'b0;
      wait (results_pending == 0);
      @(negedge clock);
   endtask

   // One expression and its end marker. Most are well nested with noise mixed
   // in; a few start with a stray closer, and long ones mostly push, so that
   // they overflow the stack.
   task automatic send_expression();
      logic [1:0] codes[$];
      logic [1:0] code;
      int         len;
      int         pick;
      int         pop_limit;
      bit         deep;
      deep = $urandom_range(99) < 12;
      len = deep ? $urandom_range(34, 14) : $urandom_range(8, 0);
      pop_limit = deep ? 22 : 50;
      if ($urandom_range(99) < 8) push_item(closer_byte(2'($urandom_range(2))), 1'b0);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            push_item(8'($urandom_range(255)), 1'b0);
         end else if (pick < 14) begin
            push_item(closer_byte(2'($urandom_range(2))), 1'b0);
         end else if (codes.size() > 0 && pick < pop_limit) begin
            push_item(closer_byte(codes[$]), 1'b0);
            void'(codes.pop_back());
         end else begin
            code = 2'($urandom_range(2));
            push_item(opener_byte(code), 1'b0);
            codes.push_back(code);
         end
      end
      if ($urandom_range(99) < 65) begin
         while (codes.size() > 0) begin
            push_item(closer_byte(codes[$]), 1'b0);
            void'(codes.pop_back());
         end
      end
      push_item(8'($urandom_range(255)), 1'b1);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= steady || ($urandom_range(99) >= 7);
      end
   end

   initial begin
      #2_000_000;
      $display("bracket_balance_checker_top test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      steady = 1'b0;
      counted_items = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Expression with no brackets; the end marker's character is ignored.
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      // A closer that does not match the top is skipped.
      push_item(bbc_pkg::CHAR_OPEN_BRACE, 1'b0);
      push_item(bbc_pkg::CHAR_CLOSE_SQUARE, 1'b0);
      push_item(bbc_pkg::CHAR_CLOSE_BRACE, 1'b0);
      push_item(bbc_pkg::CHAR_OPEN_PAREN, 1'b1);
      // Closer on an empty stack aborts; later characters and the end marker
      // give nothing.
      push_item(bbc_pkg::CHAR_CLOSE_PAREN, 1'b0);
      push_item(bbc_pkg::CHAR_OPEN_SQUARE, 1'b0);
      push_item(bbc_pkg::CHAR_CLOSE_PAREN, 1'b1);
      // Fill the stack, overflow it once, then drain every unclosed opener.
      for (int k = 0; k <= bbc_pkg::DefaultStackDepth; k++)
         push_item(opener_byte(2'(k % 3)), 1'b0);
      push_item(8'h00, 1'b1);
      pause_for_results();

      for (int n = 0; counted_items < RANDOM_ITEMS; n++) begin
         steady = counted_items >= 150 && counted_items < 250;
         send_expression();
         if (n % 25 == 24) pause_for_results();
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      wait (results_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("bracket_balance_checker_top test passed");
      else
         $display("bracket_balance_checker_top test failed");
      $finish;
   end

endmodule
`default_nettype wire
